FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the shape pair overlap checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off while reset is high.
`define SPOT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Fixed delay from antecedent to consequent, off while reset is high.
`define SPOT_ASSERT_DELAY(lbl, clk, rst, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define SPOT_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/spot_pkg.sv
// ----------------------------------------------------------------------------
// spot_pkg
// Shared types, codes and helpers for the shape pair overlap pipeline.
// ----------------------------------------------------------------------------
package spot_pkg;

  // Collider kind codes on the input ports.
  localparam logic [1:0] KIND_CIRCLE = 2'd0;
  localparam logic [1:0] KIND_AABB   = 2'd1;
  localparam logic [1:0] KIND_OBB    = 2'd2;

  // Axis distances are Q1.14 dot products scaled up to the Q.28 reach.
  localparam int DistShift = 14;

  // Which test decides the pair.
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ROUND,
    MODE_BOX,
    MODE_OBB
  } mode_t;

  // Stage-one decode: mode, box result and the round-test distances.
  typedef struct packed {
    mode_t       mode;
    logic        box_hit;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] r;
  } front_t;

  // Extents handed to the oriented-box reach products.
  typedef struct packed {
    logic [14:0] ahx;
    logic [14:0] ahy;
    logic [14:0] bhx;
    logic [14:0] bhy;
  } ext_t;

  // Products between box axis components.
  typedef struct packed {
    logic signed [31:0] ac_ac;
    logic signed [31:0] as_as;
    logic signed [31:0] bc_bc;
    logic signed [31:0] bs_bs;
    logic signed [31:0] ac_bc;
    logic signed [31:0] as_bs;
    logic signed [31:0] ac_bs;
    logic signed [31:0] as_bc;
  } axis_prod_t;

  // Products between the center offset and the box axis components.
  typedef struct packed {
    logic signed [31:0] dx_ac;
    logic signed [31:0] dy_as;
    logic signed [31:0] dx_as;
    logic signed [31:0] dy_ac;
    logic signed [31:0] dx_bc;
    logic signed [31:0] dy_bs;
    logic signed [31:0] dx_bs;
    logic signed [31:0] dy_bc;
  } off_prod_t;

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(~v + 16'sd1) : v;
  endfunction

  // Distance past a half extent, floored at zero.
  function automatic logic [15:0] clamp_sub(input logic [15:0] a, input logic [14:0] h);
    logic [16:0] d;
    d = {1'b0, a} - {2'b00, h};
    return d[16] ? 16'd0 : d[15:0];
  endfunction

  // Magnitude of a 33-bit signed sum; sums here never pass 2^31 in size.
  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  function automatic logic signed [32:0] add33(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return {a[31], a} + {b[31], b};
  endfunction

  function automatic logic signed [32:0] sub33(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

endpackage

FILE: hw/rtl/spot_front.sv
// ----------------------------------------------------------------------------
// spot_front
// Stage one: kind decode, box extent test, clamp distances and all
// 16x16 products for the oriented-box axes.
// ----------------------------------------------------------------------------
module spot_front (
  input  logic                clk,
  input  logic [1:0]          kind_a,
  input  logic [1:0]          kind_b,
  input  logic signed [15:0]  offset_x,
  input  logic signed [15:0]  offset_y,
  input  logic [14:0]         a_extent_x,
  input  logic [14:0]         a_extent_y,
  input  logic signed [15:0]  a_axis_cos,
  input  logic signed [15:0]  a_axis_sin,
  input  logic [14:0]         b_extent_x,
  input  logic [14:0]         b_extent_y,
  input  logic signed [15:0]  b_axis_cos,
  input  logic signed [15:0]  b_axis_sin,
  output spot_pkg::front_t     front,
  output spot_pkg::ext_t       ext,
  output spot_pkg::axis_prod_t ap,
  output spot_pkg::off_prod_t  op
);
  import spot_pkg::*;

  logic [15:0] adx;
  logic [15:0] ady;
  logic [15:0] sum_x;
  logic [15:0] sum_y;
  front_t      front_next;

  assign adx   = mag16(offset_x);
  assign ady   = mag16(offset_y);
  assign sum_x = {1'b0, a_extent_x} + {1'b0, b_extent_x};
  assign sum_y = {1'b0, a_extent_y} + {1'b0, b_extent_y};

  always_comb begin
    front_next.mode    = MODE_NONE;
    front_next.box_hit = (adx <= sum_x) && (ady <= sum_y);
    front_next.qx      = adx;
    front_next.qy      = ady;
    front_next.r       = sum_x;
    unique case ({kind_a, kind_b})
      {KIND_CIRCLE, KIND_CIRCLE}: begin
        front_next.mode = MODE_ROUND;
      end
      {KIND_CIRCLE, KIND_AABB}: begin
        front_next.mode = MODE_ROUND;
        front_next.qx   = clamp_sub(adx, b_extent_x);
        front_next.qy   = clamp_sub(ady, b_extent_y);
        front_next.r    = {1'b0, a_extent_x};
      end
      {KIND_AABB, KIND_CIRCLE}: begin
        front_next.mode = MODE_ROUND;
        front_next.qx   = clamp_sub(adx, a_extent_x);
        front_next.qy   = clamp_sub(ady, a_extent_y);
        front_next.r    = {1'b0, b_extent_x};
      end
      {KIND_AABB, KIND_AABB}: begin
        front_next.mode = MODE_BOX;
      end
      {KIND_OBB, KIND_OBB}: begin
        front_next.mode = MODE_OBB;
      end
      default: begin
        front_next.mode = MODE_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    front    <= front_next;
    ext.ahx  <= a_extent_x;
    ext.ahy  <= a_extent_y;
    ext.bhx  <= b_extent_x;
    ext.bhy  <= b_extent_y;
    ap.ac_ac <= a_axis_cos * a_axis_cos;
    ap.as_as <= a_axis_sin * a_axis_sin;
    ap.bc_bc <= b_axis_cos * b_axis_cos;
    ap.bs_bs <= b_axis_sin * b_axis_sin;
    ap.ac_bc <= a_axis_cos * b_axis_cos;
    ap.as_bs <= a_axis_sin * b_axis_sin;
    ap.ac_bs <= a_axis_cos * b_axis_sin;
    ap.as_bc <= a_axis_sin * b_axis_cos;
    op.dx_ac <= offset_x * a_axis_cos;
    op.dy_as <= offset_y * a_axis_sin;
    op.dx_as <= offset_x * a_axis_sin;
    op.dy_ac <= offset_y * a_axis_cos;
    op.dx_bc <= offset_x * b_axis_cos;
    op.dy_bs <= offset_y * b_axis_sin;
    op.dx_bs <= offset_x * b_axis_sin;
    op.dy_bc <= offset_y * b_axis_cos;
  end

endmodule

FILE: hw/rtl/spot_round.sv
// ----------------------------------------------------------------------------
// spot_round
// Stages two and three of the circle tests: square the distances and the
// radius, then compare the squared distance with the squared radius.
// ----------------------------------------------------------------------------
module spot_round (
  input  logic             clk,
  input  spot_pkg::front_t front,
  output logic             hit
);
  import spot_pkg::*;

  logic [31:0] sq_x;
  logic [31:0] sq_y;
  logic [31:0] sq_r;

  always_ff @(posedge clk) begin
    sq_x <= 32'(front.qx) * 32'(front.qx);
    sq_y <= 32'(front.qy) * 32'(front.qy);
    sq_r <= 32'(front.r) * 32'(front.r);
    hit  <= ({1'b0, sq_x} + {1'b0, sq_y}) <= {1'b0, sq_r};
  end

endmodule

FILE: hw/rtl/spot_obb.sv
// ----------------------------------------------------------------------------
// spot_obb
// Stages two and three of the oriented-box separating-axis test: fold the
// products into axis norms, cross terms and offset projections, scale the
// extents by them, then compare reach against distance on all four axes.
// ----------------------------------------------------------------------------
module spot_obb (
  input  logic                 clk,
  input  spot_pkg::ext_t       ext,
  input  spot_pkg::axis_prod_t ap,
  input  spot_pkg::off_prod_t  op,
  output logic                 hit
);
  import spot_pkg::*;

  localparam int ProdW  = 47;
  localparam int ReachW = ProdW + 2;

  // Stage two: norms, cross terms |P| and |Q|, offset projections.
  ext_t        ext2;
  logic [31:0] na;
  logic [31:0] nb;
  logic [31:0] pm;
  logic [31:0] qm;
  logic [31:0] d2 [4];

  // Stage three: extent products per axis, projections carried along.
  logic [ProdW-1:0] prod [4][3];
  logic [31:0]      d3   [4];

  logic [3:0] axis_ok;

  always_ff @(posedge clk) begin
    ext2  <= ext;
    na    <= mag33(add33(ap.ac_ac, ap.as_as));
    nb    <= mag33(add33(ap.bc_bc, ap.bs_bs));
    pm    <= mag33(add33(ap.ac_bc, ap.as_bs));
    qm    <= mag33(sub33(ap.as_bc, ap.ac_bs));
    d2[0] <= mag33(add33(op.dx_ac, op.dy_as));
    d2[1] <= mag33(sub33(op.dy_ac, op.dx_as));
    d2[2] <= mag33(add33(op.dx_bc, op.dy_bs));
    d2[3] <= mag33(sub33(op.dy_bc, op.dx_bs));
  end

  always_ff @(posedge clk) begin
    // first box x axis
    prod[0][0] <= ProdW'(ext2.ahx) * ProdW'(na);
    prod[0][1] <= ProdW'(ext2.bhx) * ProdW'(pm);
    prod[0][2] <= ProdW'(ext2.bhy) * ProdW'(qm);
    // first box y axis
    prod[1][0] <= ProdW'(ext2.ahy) * ProdW'(na);
    prod[1][1] <= ProdW'(ext2.bhx) * ProdW'(qm);
    prod[1][2] <= ProdW'(ext2.bhy) * ProdW'(pm);
    // second box x axis
    prod[2][0] <= ProdW'(ext2.ahx) * ProdW'(pm);
    prod[2][1] <= ProdW'(ext2.ahy) * ProdW'(qm);
    prod[2][2] <= ProdW'(ext2.bhx) * ProdW'(nb);
    // second box y axis
    prod[3][0] <= ProdW'(ext2.ahx) * ProdW'(qm);
    prod[3][1] <= ProdW'(ext2.ahy) * ProdW'(pm);
    prod[3][2] <= ProdW'(ext2.bhy) * ProdW'(nb);
    d3 <= d2;
  end

  always_comb begin
    logic [ReachW-1:0] reach;
    logic [ReachW-1:0] span;
    for (int i = 0; i < 4; i++) begin
      reach = {2'b00, prod[i][0]} + {2'b00, prod[i][1]} + {2'b00, prod[i][2]};
      span  = {{(ReachW - 32 - DistShift){1'b0}}, d3[i], {DistShift{1'b0}}};
      axis_ok[i] = span <= reach;
    end
  end

  assign hit = &axis_ok;

endmodule

FILE: hw/rtl/shape_pair_overlap_test.sv
// ----------------------------------------------------------------------------
// shape_pair_overlap_test
// Four-stage overlap test for one pair of 2D colliders per clock outside reset.
// ----------------------------------------------------------------------------
// Output: done and hit show a pair's answer for one cycle, once its transfer has
//   passed the v1, v2 and v3 valid registers into the done register.
// Throughput: one pair per clock outside reset; the four register stages never stall.
// Reset: rst clears the stage valid bits and done; busy is high during reset.
// The receiver cannot stall: every answer is on the ports for exactly one cycle.
module shape_pair_overlap_test (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_a,
  input  logic [1:0]         kind_b,
  input  logic signed [15:0] offset_x,
  input  logic signed [15:0] offset_y,
  input  logic [14:0]        a_extent_x,
  input  logic [14:0]        a_extent_y,
  input  logic signed [15:0] a_axis_cos,
  input  logic signed [15:0] a_axis_sin,
  input  logic [14:0]        b_extent_x,
  input  logic [14:0]        b_extent_y,
  input  logic signed [15:0] b_axis_cos,
  input  logic signed [15:0] b_axis_sin,
  output logic               done,
  output logic               hit
);
  import spot_pkg::*;

  // Stage one outputs.
  front_t     front;
  ext_t       ext;
  axis_prod_t ap;
  off_prod_t  op;

  // Valid bits and decode that ride alongside the datapath stages.
  logic  v1;
  logic  v2;
  logic  v3;
  mode_t mode2;
  mode_t mode3;
  logic  box2;
  logic  box3;

  logic  round_hit;
  logic  obb_hit;
  logic  hit_next;
  logic  accept;

  // The pipeline takes a transfer every cycle; only reset holds it off.
  assign busy   = rst;
  assign accept = start && !busy;

  // Stage one: decode the kinds, do the box extent test, clamp the circle
  // distances and form every axis and offset product.
  spot_front u_front (
    .clk        (clk),
    .kind_a     (kind_a),
    .kind_b     (kind_b),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .a_extent_x (a_extent_x),
    .a_extent_y (a_extent_y),
    .a_axis_cos (a_axis_cos),
    .a_axis_sin (a_axis_sin),
    .b_extent_x (b_extent_x),
    .b_extent_y (b_extent_y),
    .b_axis_cos (b_axis_cos),
    .b_axis_sin (b_axis_sin),
    .front      (front),
    .ext        (ext),
    .ap         (ap),
    .op         (op)
  );

  // Stages two and three for circle pairs and circle-box pairs.
  spot_round u_round (
    .clk   (clk),
    .front (front),
    .hit   (round_hit)
  );

  // Stages two and three for oriented-box pairs; the compare lands in
  // the output stage below.
  spot_obb u_obb (
    .clk (clk),
    .ext (ext),
    .ap  (ap),
    .op  (op),
    .hit (obb_hit)
  );

  // Carry decode through stages two and three, untouched by reset.
  always_ff @(posedge clk) begin
    mode2 <= front.mode;
    mode3 <= mode2;
    box2  <= front.box_hit;
    box3  <= box2;
  end

  // Pick the answer of the test that the pair's kinds select; an oriented box
  // paired with another kind, and unknown codes, give no hit.
  always_comb begin
    case (mode3)
      MODE_ROUND: hit_next = round_hit;
      MODE_BOX:   hit_next = box3;
      MODE_OBB:   hit_next = obb_hit;
      default:    hit_next = 1'b0;
    endcase
  end

  // Advance valid bits one stage per clock; drop everything on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // Output register for the answer.
  always_ff @(posedge clk) begin
    hit <= hit_next;
  end

endmodule

FILE: hw/rtl/spot_checker.sv
// ----------------------------------------------------------------------------
// spot_checker
// Port-level timing checks for the shape pair overlap pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spot_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // Every transfer gives exactly one strobe after a fixed latency.
  `SPOT_ASSERT_DELAY(a_done_follows, clk, rst, start && !busy, 4, done, "transfer lost")
  `SPOT_ASSERT_IMP(a_done_source, clk, rst, done, $past(start && !busy, 4), "strobe invented")
  // Reset flushes the pipeline.
  `SPOT_ASSERT_NEXT(a_reset_flush, clk, rst, !done, "strobe after reset")

endmodule

bind shape_pair_overlap_test spot_checker u_spot_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
